### src/button_click_long_press_detector_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button click / long press detector
// Clocked on clk_i; the first form is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_LONG_PRESS_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_LONG_PRESS_DETECTOR_MACROS_SVH

// checked only outside reset
`define BCLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define BCLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### src/bclp_pkg.sv
// ----------------------------------------------------------------------------
// bclp_pkg
// Shared types and constants of the button click / long press detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bclp_pkg;

  localparam int NumKeys = 8;
  localparam int KeyW    = 3;
  localparam int TickW   = 32;
  localparam int MaskW   = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 32;

  localparam logic [TickW-1:0] DebounceRst = 32'd50;
  localparam logic [TickW-1:0] LongRst     = 32'd1000;
  localparam logic [TickW-1:0] DoubleRst   = 32'd300;
  localparam logic [MaskW-1:0] MaskRst     = 8'd0;

  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvClick  = 2'd1,
    EvDouble = 2'd2,
    EvLong   = 2'd3
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDebounce = 2'd0,
    CfgLong     = 2'd1,
    CfgDouble   = 2'd2,
    CfgMask     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [TickW-1:0] debounce;
    logic [TickW-1:0] long_press;
    logic [TickW-1:0] double_click;
    logic [MaskW-1:0] key_mask;
  } cfg_t;

  typedef struct packed {
    logic             prev_level;
    logic             long_fired;
    logic [1:0]       clicks;
    logic [TickW-1:0] press_time;
    logic [TickW-1:0] release_time;
  } key_state_t;

endpackage

### src/bclp_sample_if.sv
// ----------------------------------------------------------------------------
// bclp_sample_if
// Valid/ready channel carrying one poll sample of one key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bclp_sample_if;
  logic                       valid;
  logic                       ready;
  logic [bclp_pkg::KeyW-1:0]  key_index;
  logic                       pressed;
  logic [bclp_pkg::TickW-1:0] now_tick;

  modport source (output valid, key_index, pressed, now_tick, input ready);
  modport sink   (input valid, key_index, pressed, now_tick, output ready);
endinterface

### src/bclp_event_if.sv
// ----------------------------------------------------------------------------
// bclp_event_if
// Valid/ready channel carrying one detector result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bclp_event_if;
  logic                      valid;
  logic                      ready;
  logic [bclp_pkg::KeyW-1:0] key_number;
  logic [1:0]                event_res;

  modport source (output valid, key_number, event_res, input ready);
  modport sink   (input valid, key_number, event_res, output ready);
endinterface

### src/bclp_cfg.sv
// ----------------------------------------------------------------------------
// bclp_cfg
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bclp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bclp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bclp_pkg::CfgW-1:0]    cfg_wdata_i,
  output bclp_pkg::cfg_t               cfg_o
);

  bclp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (bclp_pkg::cfg_idx_e'(cfg_idx_i))
        bclp_pkg::CfgDebounce: cfg_d.debounce     = cfg_wdata_i;
        bclp_pkg::CfgLong:     cfg_d.long_press   = cfg_wdata_i;
        bclp_pkg::CfgDouble:   cfg_d.double_click = cfg_wdata_i;
        bclp_pkg::CfgMask:     cfg_d.key_mask     = cfg_wdata_i[bclp_pkg::MaskW-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce     <= bclp_pkg::DebounceRst;
      cfg_q.long_press   <= bclp_pkg::LongRst;
      cfg_q.double_click <= bclp_pkg::DoubleRst;
      cfg_q.key_mask     <= bclp_pkg::MaskRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/bclp_keys.sv
// ----------------------------------------------------------------------------
// bclp_keys
// Per-key state registers and the single-pass click / long press update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bclp_keys (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bclp_pkg::cfg_t             cfg_i,
  input  logic                       upd_i,      // commit this sample's update
  input  logic [bclp_pkg::KeyW-1:0]  key_i,
  input  logic                       pressed_i,
  input  logic [bclp_pkg::TickW-1:0] now_i,
  output bclp_pkg::event_e           ev_o
);

  bclp_pkg::key_state_t st_q [bclp_pkg::NumKeys];
  bclp_pkg::key_state_t cur, nxt;
  bclp_pkg::event_e     ev;
  logic                 key_ok, active;
  logic [bclp_pkg::TickW-1:0] held, quiet;

  always_comb begin
    key_ok = (32'(key_i) < bclp_pkg::NumKeys);
    active = key_ok && cfg_i.key_mask[key_i];
    cur    = st_q[key_i];
    nxt    = cur;
    ev     = bclp_pkg::EvNone;
    held   = now_i - cur.press_time;
    quiet  = now_i - cur.release_time;

    if (pressed_i && !cur.prev_level) begin
      // press edge: restart timing, re-arm long press
      nxt.press_time = now_i;
      nxt.long_fired = 1'b0;
      held           = '0;
    end else if (!pressed_i && cur.prev_level) begin
      // release edge: held still measures the finished press
      nxt.release_time = now_i;
      quiet            = '0;
      if (held >= cfg_i.debounce && cur.clicks != 2'd3) begin
        nxt.clicks = cur.clicks + 2'd1;
      end
    end

    if (pressed_i && !nxt.long_fired && held >= cfg_i.long_press) begin
      ev             = bclp_pkg::EvLong;
      nxt.long_fired = 1'b1;
      nxt.clicks     = 2'd0;
    end

    if (!pressed_i && nxt.clicks != 2'd0 && quiet >= cfg_i.double_click) begin
      case (nxt.clicks)
        2'd1:    ev = bclp_pkg::EvClick;
        2'd2:    ev = bclp_pkg::EvDouble;
        default: ev = bclp_pkg::EvNone;   // triple and more: dropped
      endcase
      nxt.clicks = 2'd0;
    end

    nxt.prev_level = pressed_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < bclp_pkg::NumKeys; k++) begin
        st_q[k] <= '0;
      end
    end else if (upd_i && active) begin
      st_q[key_i] <= nxt;
    end
  end

  assign ev_o = active ? ev : bclp_pkg::EvNone;

endmodule

### src/button_click_long_press_detector.sv
// Path: a transferred sample is registered in s1, then moves with its event into
//   the result register. Throughput: one sample per cycle while the result
//   register is empty or being taken; the key state is written as the sample
//   leaves s1, so back-to-back samples of the same key see each other's updates.
// Reset: asynchronous, active low; clears all per-key state, both pipeline
//   valids, and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// button_click_long_press_detector
// Click, double click and long press detection on polled key samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_click_long_press_detector (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bclp_sample_if.sink                  sample_i,
  bclp_event_if.source                 event_o,
  input  logic                         cfg_we_i,
  input  logic [bclp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bclp_pkg::CfgW-1:0]    cfg_wdata_i
);

  // Pipeline:
  //   input register (s1) -> key state update + event decode -> result register
  // The state write and the result load happen on the same edge, so the next
  // sample sitting in s1 always reads up-to-date key state.

  bclp_pkg::cfg_t cfg;

  // input register
  logic                       s1_valid_q;
  logic [bclp_pkg::KeyW-1:0]  s1_key_q;
  logic                       s1_pressed_q;
  logic [bclp_pkg::TickW-1:0] s1_now_q;

  // result register
  logic                      out_valid_q;
  logic [bclp_pkg::KeyW-1:0] out_key_q;
  bclp_pkg::event_e          out_ev_q;

  bclp_pkg::event_e ev;
  logic             s1_adv;     // s1 item moves into the result register
  logic             in_xfer;    // sample transfer on the input channel

  // s1 drains whenever the result register is empty or being taken
  assign s1_adv  = s1_valid_q && (!out_valid_q || event_o.ready);
  assign sample_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer = sample_i.valid && sample_i.ready;

  bclp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bclp_keys u_keys (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .upd_i     (s1_adv),
    .key_i     (s1_key_q),
    .pressed_i (s1_pressed_q),
    .now_i     (s1_now_q),
    .ev_o      (ev)
  );

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // input register payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_key_q     <= sample_i.key_index;
      s1_pressed_q <= sample_i.pressed;
      s1_now_q     <= sample_i.now_tick;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (event_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_key_q <= s1_key_q;
      out_ev_q  <= ev;
    end
  end

  assign event_o.valid      = out_valid_q;
  assign event_o.key_number = out_key_q;
  assign event_o.event_res  = 2'(out_ev_q);

endmodule

### src/bclp_checker.sv
// ----------------------------------------------------------------------------
// bclp_checker
// Port-level checks of the detector, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_click_long_press_detector_macros.svh"

module bclp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic [bclp_pkg::KeyW-1:0] in_key_i,
  input logic                      in_pressed_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [bclp_pkg::KeyW-1:0] out_key_i,
  input logic [1:0]                out_ev_i
);

  `BCLP_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_i, "result valid during reset")

  `BCLP_ASSERT(a_out_hold,
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_key_i) && $stable(out_ev_i),
    "stalled result changed")

  `BCLP_ASSERT(a_ready_only_on_stall,
    !in_ready_i |-> out_valid_i && !out_ready_i,
    "input stalled while output free")

  `BCLP_ASSERT(a_latency_key,
    (in_valid_i && in_ready_i) ##1 (!out_valid_i || out_ready_i) |=>
      out_valid_i && out_key_i == $past(in_key_i, 2),
    "result missing or wrong key")

  `BCLP_ASSERT(a_event_level,
    (in_valid_i && in_ready_i) ##1 (!out_valid_i || out_ready_i) |=>
      (out_ev_i != 2'(bclp_pkg::EvLong) || $past(in_pressed_i, 2)) &&
      (out_ev_i == 2'(bclp_pkg::EvNone) || out_ev_i == 2'(bclp_pkg::EvLong) ||
       !$past(in_pressed_i, 2)),
    "event inconsistent with key level")

endmodule

bind button_click_long_press_detector bclp_checker u_bclp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (sample_i.valid),
  .in_ready_i   (sample_i.ready),
  .in_key_i     (sample_i.key_index),
  .in_pressed_i (sample_i.pressed),
  .out_valid_i  (event_o.valid),
  .out_ready_i  (event_o.ready),
  .out_key_i    (event_o.key_number),
  .out_ev_i     (event_o.event_res)
);

### bench/button_click_long_press_detector_tb.sv
// ----------------------------------------------------------------------------
// button_click_long_press_detector_tb
// Self-checking bench: polled key samples go in over a valid/ready channel,
// a cycle-free predictor works out the event of every transfer, and the
// monitor matches each event transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_click_long_press_detector_tb;
  import bclp_pkg::*;

  // Stimulus entries: a poll sample, or a register write that waits for idle.
  typedef enum logic {
    ItemPoll,
    ItemCfg
  } item_kind_e;

  typedef struct packed {
    item_kind_e       kind;
    logic [KeyW-1:0]  key;
    logic             lvl;
    logic [TickW-1:0] tick;
    cfg_idx_e         idx;
    logic [CfgW-1:0]  data;
    logic             hold_mark;  // start the long output hold-off here
  } stim_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    event_e          ev;
  } key_event_t;

  localparam int unsigned PollTarget = 1300;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdleWait   = 4;   // quiet output margin before a register write
  localparam int unsigned TailCycles = 8;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we;
  cfg_idx_e cfg_idx;
  logic [CfgW-1:0] cfg_wdata;

  bclp_sample_if sample_bus ();
  bclp_event_if  event_bus ();

  button_click_long_press_detector DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_bus),
    .event_o     (event_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  stim_t      poll_q [$];    // pending samples and register writes
  key_event_t event_q [$];   // predicted events, oldest first

  // predictor copy of the block
  cfg_t       model_cfg;
  key_state_t key_track [NumKeys];

  // generator shadow, used only to shape the stimulus
  cfg_t             gen_cfg;
  logic             gen_level [NumKeys];
  logic [TickW-1:0] phase_start [NumKeys];
  logic [TickW-1:0] phase_len [NumKeys];
  logic [TickW-1:0] tick_gen;
  int unsigned      polls_made;

  int unsigned fail_count;
  logic        poll_taken;   // set on a sample transfer, cleared by the driver
  logic        hold_req;
  logic        hold_off;
  int unsigned gap_left;
  int unsigned src_burst;
  int unsigned stall_left;
  int unsigned sink_burst;
  int unsigned idle_cycles;

  // --------------------------------------------------------------------------
  // Event predictor: one call per accepted sample, updates the key's state.
  // Disabled keys leave their state alone and report nothing.
  // --------------------------------------------------------------------------
  function automatic event_e detect_event(input logic [KeyW-1:0] k, input logic lvl,
                                          input logic [TickW-1:0] now);
    key_state_t       st;
    logic [TickW-1:0] held;
    logic [TickW-1:0] quiet;
    event_e           ev;
    ev = EvNone;
    if (!model_cfg.key_mask[k]) return EvNone;
    st = key_track[k];
    if (lvl != st.prev_level) begin
      if (lvl) begin
        st.press_time = now;
        st.long_fired = 1'b0;
      end else begin
        st.release_time = now;
        held = now - st.press_time;
        // click counter saturates at three
        if (held >= model_cfg.debounce && st.clicks != 2'd3) st.clicks = st.clicks + 2'd1;
      end
    end
    // long press fires once per press and drops any pending clicks
    held = now - st.press_time;
    if (lvl && !st.long_fired && held >= model_cfg.long_press) begin
      ev            = EvLong;
      st.long_fired = 1'b1;
      st.clicks     = 2'd0;
    end
    // quiet time after release reports the clicks; three or more report nothing
    quiet = now - st.release_time;
    if (!lvl && st.clicks != 2'd0 && quiet >= model_cfg.double_click) begin
      if (st.clicks == 2'd1) ev = EvClick;
      else if (st.clicks == 2'd2) ev = EvDouble;
      st.clicks = 2'd0;
    end
    st.prev_level = lvl;
    key_track[k]  = st;
    return ev;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  function automatic logic [TickW-1:0] sat_tick(input longint v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[TickW-1:0];
  endfunction

  // How long the next press or release phase of a key should last, spread
  // around the thresholds currently programmed.
  function automatic logic [TickW-1:0] phase_span(input logic lvl);
    logic [TickW-1:0] d;
    logic [TickW-1:0] l;
    logic [TickW-1:0] g;
    d = gen_cfg.debounce;
    l = gen_cfg.long_press;
    g = gen_cfg.double_click;
    if (lvl) begin
      case ($urandom_range(0, 2))
        0: return $urandom_range(0, d);             // bounce or bare click
        1: return $urandom_range(d, l);             // click
        default: return sat_tick(longint'(l) + $urandom_range(0, l / 2 + 20));
      endcase
    end
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, g);  // next click of a burst
    return sat_tick(longint'(g) + $urandom_range(0, g / 2 + 20));
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_sample(input int unsigned k, input logic lvl, input logic [TickW-1:0] t,
                             input logic mark = 1'b0);
    stim_t s;
    s           = '0;
    s.kind      = ItemPoll;
    s.key       = k[KeyW-1:0];
    s.lvl       = lvl;
    s.tick      = t;
    s.hold_mark = mark;
    poll_q.push_back(s);
    if (gen_cfg.key_mask[k]) begin
      polls_made++;
      if (lvl != gen_level[k]) begin
        gen_level[k]   = lvl;
        phase_start[k] = t;
        phase_len[k]   = phase_span(lvl);
      end
    end
  endtask

  task automatic push_config(input cfg_idx_e idx, input logic [CfgW-1:0] v);
    stim_t s;
    s      = '0;
    s.kind = ItemCfg;
    s.idx  = idx;
    s.data = v;
    poll_q.push_back(s);
    case (idx)
      CfgDebounce: gen_cfg.debounce     = v;
      CfgLong:     gen_cfg.long_press   = v;
      CfgDouble:   gen_cfg.double_click = v;
      CfgMask:     gen_cfg.key_mask     = v[MaskW-1:0];
      default: ;
    endcase
  endtask

  // Well-formed press/release sequences on a few active keys, with about
  // one sample in twelve given a random level and one in ten sent to any key.
  task automatic random_phase(input int unsigned n, input int unsigned step_max,
                              input logic mark_hold);
    logic [NumKeys-1:0] active;
    logic [TickW-1:0]   span;
    int unsigned        k;
    int unsigned        target;
    logic               lvl;
    active = '0;
    repeat ($urandom_range(1, 3)) active[$urandom_range(0, NumKeys - 1)] = 1'b1;
    if ((active & gen_cfg.key_mask) != '0) active = active & gen_cfg.key_mask;
    else active = gen_cfg.key_mask;
    target = polls_made + n;
    while (polls_made < target) begin
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(0, NumKeys - 1);
      end else begin
        do k = $urandom_range(0, NumKeys - 1); while (!active[k]);
      end
      tick_gen = tick_gen + $urandom_range(0, step_max);
      span     = tick_gen - phase_start[k];
      if ($urandom_range(0, 11) == 0) lvl = $urandom_range(0, 1);
      else if (span >= phase_len[k]) lvl = !gen_level[k];
      else lvl = gen_level[k];
      push_sample(k, lvl, tick_gen, mark_hold && (target - polls_made == n - 20));
    end
  endtask

  task automatic build_stimulus();
    int unsigned      phase_no;
    int unsigned      mode;
    int unsigned      n;
    int unsigned      step;
    logic [TickW-1:0] d;
    logic [TickW-1:0] l;
    logic [TickW-1:0] g;

    // --- directed, reset settings (50 / 1000 / 300) ---
    // all keys disabled after reset: a full press is ignored
    push_sample(1, 1'b1, 32'd100);
    push_sample(1, 1'b0, 32'd200);
    push_config(CfgMask, 32'h0000_00FF);
    // double click
    push_sample(2, 1'b1, 32'd2000);
    push_sample(2, 1'b0, 32'd2060);
    push_sample(2, 1'b1, 32'd2100);
    push_sample(2, 1'b0, 32'd2200);
    push_sample(2, 1'b0, 32'd2500);
    // long press exactly at threshold, then the release still counts a click
    push_sample(3, 1'b1, 32'd3000);
    push_sample(3, 1'b1, 32'd4000);
    push_sample(3, 1'b1, 32'd4500);
    push_sample(3, 1'b0, 32'd4600);
    push_sample(3, 1'b0, 32'd4900);
    // three clicks: cleared without an event
    push_sample(4, 1'b1, 32'd5000);
    push_sample(4, 1'b0, 32'd5100);
    push_sample(4, 1'b1, 32'd5150);
    push_sample(4, 1'b0, 32'd5250);
    push_sample(4, 1'b1, 32'd5300);
    push_sample(4, 1'b0, 32'd5400);
    push_sample(4, 1'b0, 32'd5800);
    // click across the tick wrap, quiet time one short then exact
    push_sample(7, 1'b1, 32'hFFFF_FF00);
    push_sample(7, 1'b0, 32'h0000_0010);
    push_sample(7, 1'b0, 32'h0000_013B);
    push_sample(7, 1'b0, 32'h0000_013C);

    // --- zero thresholds: long press on the press sample, click on release ---
    push_config(CfgDebounce, 32'd0);
    push_config(CfgLong, 32'd0);
    push_config(CfgDouble, 32'd0);
    push_sample(5, 1'b1, 32'd7000);
    push_sample(5, 1'b0, 32'd7001);

    // --- all-ones thresholds: only a wrapped difference of 2^32-1 reaches them ---
    push_config(CfgDebounce, 32'hFFFF_FFFF);
    push_config(CfgLong, 32'hFFFF_FFFF);
    push_config(CfgDouble, 32'hFFFF_FFFF);
    push_sample(6, 1'b1, 32'd100);
    push_sample(6, 1'b0, 32'd99);
    push_sample(6, 1'b0, 32'd98);
    push_sample(6, 1'b1, 32'd200);
    push_sample(6, 1'b1, 32'd199);

    // --- random phases, each with its own settings ---
    tick_gen = 32'd10000;
    phase_no = 0;
    while (polls_made < PollTarget) begin
      mode = $urandom_range(0, 9);
      n    = $urandom_range(90, 160);
      if (mode <= 6) begin
        d    = $urandom_range(0, 15);
        l    = d + $urandom_range(5, 80);
        g    = $urandom_range(3, 50);
        step = $urandom_range(1, 6);
      end else if (mode == 7) begin
        // around the reset settings
        d    = $urandom_range(20, 100);
        l    = $urandom_range(500, 1500);
        g    = $urandom_range(100, 400);
        step = $urandom_range(20, 80);
      end else if (mode == 8) begin
        // full-range settings and tick steps
        d    = $urandom;
        l    = $urandom;
        g    = $urandom;
        step = $urandom;
        n    = 40;
      end else begin
        d    = '0;
        l    = '0;
        g    = '0;
        step = $urandom_range(0, 3);
        n    = 60;
      end
      if (phase_no == 3) n = 150;   // room for the output hold-off
      // most phases rewrite every register, some keep a few old values
      if ($urandom_range(0, 4) != 0) push_config(CfgDebounce, d);
      if ($urandom_range(0, 4) != 0) push_config(CfgLong, l);
      if ($urandom_range(0, 4) != 0) push_config(CfgDouble, g);
      push_config(CfgMask, ($urandom_range(0, 1) == 0) ? 32'h0000_00FF
                                                        : CfgW'($urandom_range(1, 255)));
      case ($urandom_range(0, 7))
        0, 1: tick_gen = $urandom;
        2:    tick_gen = 32'hFFFF_FFFF - $urandom_range(0, 400);
        default: ;
      endcase
      random_phase(n, step, phase_no == 3);
      phase_no++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sample driver. Inputs change on the falling edge. A sample stays on the
  // bus until its transfer; a register write goes out only once every
  // predicted event has arrived and the output side has been quiet a while.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_samples
    logic next_valid;
    logic next_we;
    if (rst_ni) begin
      next_valid = 1'b0;
      next_we    = 1'b0;
      if (sample_bus.valid && !poll_taken) begin
        next_valid = 1'b1;   // still waiting for the transfer
      end else begin
        poll_taken = 1'b0;
        if (poll_q.size() != 0 && poll_q[0].kind == ItemCfg) begin
          idle_cycles = (event_q.size() == 0) ? idle_cycles + 1 : 0;
          if (idle_cycles >= IdleWait) begin
            next_we   = 1'b1;
            cfg_idx   <= poll_q[0].idx;
            cfg_wdata <= poll_q[0].data;
            case (poll_q[0].idx)
              CfgDebounce: model_cfg.debounce     = poll_q[0].data;
              CfgLong:     model_cfg.long_press   = poll_q[0].data;
              CfgDouble:   model_cfg.double_click = poll_q[0].data;
              CfgMask:     model_cfg.key_mask     = poll_q[0].data[MaskW-1:0];
              default: ;
            endcase
            void'(poll_q.pop_front());
            idle_cycles = 0;
          end
        end else if (gap_left != 0 && !hold_off) begin
          gap_left--;
        end else if (poll_q.size() != 0) begin
          next_valid           = 1'b1;
          sample_bus.key_index <= poll_q[0].key;
          sample_bus.pressed   <= poll_q[0].lvl;
          sample_bus.now_tick  <= poll_q[0].tick;
          if (poll_q[0].hold_mark) hold_req = 1'b1;
          // runs of back-to-back samples now and then
          if (src_burst != 0) begin
            src_burst--;
            gap_left = 0;
          end else begin
            gap_left = idle_len();
            if ($urandom_range(0, 63) == 0) src_burst = $urandom_range(30, 90);
          end
        end
      end
      sample_bus.valid <= next_valid;
      cfg_we           <= next_we;
    end
  end

  // Sample transfer: predict its event right away.
  always @(posedge clk_i) begin : take_sample
    stim_t      cur;
    key_event_t res;
    if (rst_ni && sample_bus.valid && sample_bus.ready) begin
      cur     = poll_q.pop_front();
      res.key = cur.key;
      res.ev  = detect_event(cur.key, cur.lvl, cur.tick);
      event_q.push_back(res);
      poll_taken = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Event side: random back-pressure, plus one long hold-off while the
  // driver keeps offering samples so the block fills up and stalls.
  // --------------------------------------------------------------------------
  initial begin
    wait (hold_req);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(negedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (hold_off) begin
        event_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        event_bus.ready <= 1'b0;
      end else begin
        event_bus.ready <= 1'b1;
        if (sink_burst != 0) begin
          sink_burst--;
        end else if ($urandom_range(0, 3) == 0) begin
          stall_left = idle_len();
          if ($urandom_range(0, 63) == 0) sink_burst = $urandom_range(30, 90);
        end
      end
    end
  end

  // Event transfer: compare key and event against the oldest prediction.
  always @(posedge clk_i) begin : check_events
    key_event_t want;
    if (rst_ni && event_bus.valid && event_bus.ready) begin
      if (event_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: event with nothing predicted: key %0d event %0d", $realtime,
                   event_bus.key_number, event_bus.event_res);
      end else begin
        want = event_q.pop_front();
        if (event_bus.key_number !== want.key || event_bus.event_res !== want.ev) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch: key %0d/%0d event %s/%0d (expected/actual)", $realtime,
                     want.key, event_bus.key_number, want.ev.name(), event_bus.event_res);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni               = 1'b0;
    sample_bus.valid     = 1'b0;
    sample_bus.key_index = '0;
    sample_bus.pressed   = 1'b0;
    sample_bus.now_tick  = '0;
    event_bus.ready      = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = CfgDebounce;
    cfg_wdata            = '0;

    fail_count  = 0;
    poll_taken  = 1'b0;
    hold_req    = 1'b0;
    hold_off    = 1'b0;
    gap_left    = 0;
    src_burst   = 0;
    stall_left  = 0;
    sink_burst  = 0;
    idle_cycles = 0;
    polls_made  = 0;

    // predictor and generator both start from the reset state
    model_cfg = '{debounce: DebounceRst, long_press: LongRst, double_click: DoubleRst,
                  key_mask: MaskRst};
    gen_cfg   = model_cfg;
    for (int k = 0; k < NumKeys; k++) begin
      key_track[k]   = '0;
      gen_level[k]   = 1'b0;
      phase_start[k] = '0;
      phase_len[k]   = '0;
    end

    build_stimulus();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (poll_q.size() != 0 || event_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
